FILE: design/tces_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tces_pkg: shared types and constants
// Widths, effect codes, controller states, command and status bundles.
// ---------------------------------------------------------------------------
package tces_pkg;

  localparam int PATTERN_ROWS = 64;
  localparam int ROW_W        = $clog2(PATTERN_ROWS);
  localparam int REC_W        = 16;
  localparam int FREQ_W       = 22;
  localparam int DUTY_W       = 16;

  localparam logic [FREQ_W-1:0] FREQ_MAX  = 22'h3FFFFF;
  localparam logic [DUTY_W-1:0] DUTY_HALF = 16'd32768;
  localparam logic [DUTY_W-1:0] DUTY_MIN  = 16'd655;
  localparam logic [FREQ_W-1:0] DUTY_SPAN = 22'd32113;

  // reciprocals floor(2^32 / d)
  localparam logic [28:0] RECIP_12 = 29'd357913941;
  localparam logic [28:0] RECIP_84 = 29'd51130563;
  localparam logic [28:0] RECIP_63 = 29'd68174084;

  localparam logic [3:0] EFF_ARP   = 4'h0;
  localparam logic [3:0] EFF_UP    = 4'h1;
  localparam logic [3:0] EFF_DOWN  = 4'h2;
  localparam logic [3:0] EFF_PORTA = 4'h3;
  localparam logic [3:0] EFF_VIB   = 4'h4;
  localparam logic [3:0] EFF_PWM   = 4'hC;
  localparam logic [3:0] EFF_BREAK = 4'hD;
  localparam logic [3:0] EFF_SPEED = 4'hF;

  localparam logic [5:0] NOTE_EMPTY   = 6'd0;
  localparam logic [5:0] NOTE_RELEASE = 6'd63;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_BWAIT, ST_BREAD, ST_ROW, ST_SLIDE,
    ST_MUL, ST_RECIP, ST_CORR, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {MD_NONE, MD_ARP, MD_VIB, MD_PWM} mode_t;

  typedef struct packed {
    logic brk;
    logic ld_rec;
    logic row_start;
    logic slide;
    logic mul;
    logic recip;
    logic corr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic brk_hit;
    logic out_free;
  } stat_t;

  // one octave, Q14.8
  function automatic logic [FREQ_W-1:0] octave_pitch(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd33488;
      4'd1:    v = 16'd35479;
      4'd2:    v = 16'd37589;
      4'd3:    v = 16'd39824;
      4'd4:    v = 16'd42192;
      4'd5:    v = 16'd44701;
      4'd6:    v = 16'd47359;
      4'd7:    v = 16'd50175;
      4'd8:    v = 16'd53159;
      4'd9:    v = 16'd56320;
      4'd10:   v = 16'd59669;
      4'd11:   v = 16'd63217;
      default: v = 16'd0;
    endcase
    return {6'd0, v};
  endfunction

  function automatic logic [FREQ_W-1:0] pitch_of(input logic [5:0] n);
    logic [5:0] k;
    logic [2:0] oct;
    k   = n - 6'd1;
    oct = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (k >= 6'd12) begin
        k   = k - 6'd12;
        oct = oct + 3'd1;
      end
    end
    return octave_pitch(k[3:0]) << oct;
  endfunction

endpackage

FILE: design/tces_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tces_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tces_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tces_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tces_ctrl: tick sequencer
// Steps one tick request through fetch, row start, per-tick and divide steps.
// ---------------------------------------------------------------------------
module tces_ctrl
  import tces_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  req_valid,
  input  logic  req_op,
  input  stat_t stat,
  output logic  req_ready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && req_op == OP_TICK) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.brk_hit) begin
          cmd.brk   = 1'b1;
          state_nxt = ST_BWAIT;
        end else begin
          cmd.ld_rec = 1'b1;
          state_nxt  = ST_ROW;
        end
      end
      ST_BWAIT: state_nxt = ST_BREAD;
      ST_BREAD: begin
        cmd.ld_rec = 1'b1;
        state_nxt  = ST_ROW;
      end
      ST_ROW: begin
        cmd.row_start = 1'b1;
        state_nxt     = ST_SLIDE;
      end
      ST_SLIDE: begin
        cmd.slide = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: design/tces_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tces_dp: channel datapath
// Row state, pitch and effect state, shared multiply/reciprocal divider,
// result register.
// ---------------------------------------------------------------------------
module tces_dp
  import tces_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [REC_W-1:0]  rd_rec,
  input  logic              out_ready,
  output stat_t             stat,
  output logic [ROW_W-1:0]  rd_row,
  output logic              out_valid,
  output logic              out_playing,
  output logic [FREQ_W-1:0] out_freq,
  output logic [DUTY_W-1:0] out_duty,
  output logic [ROW_W-1:0]  out_row
);

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [5:0]        tick_r, tick_nxt, tpr_r, tpr_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [REC_W-1:0]  rec_r;
  logic [FREQ_W-1:0] base_r, base_nxt, tgt_r, tgt_nxt;
  logic              tgt_vld_r, tgt_vld_nxt, active_r, active_nxt;
  logic [2:0]        vsp_r, vsp_nxt, vdp_r, vdp_nxt;
  logic signed [1:0] vdir_r, vdir_nxt;
  logic signed [4:0] voff_r, voff_nxt;
  mode_t             mode_r;
  logic [27:0]       prod_r;
  logic [24:0]       qe_r;
  logic [FREQ_W-1:0] fres_r;
  logic [DUTY_W-1:0] dres_r;
  logic              ov_r;

  logic [5:0]  note, data, rdata_f;
  logic [3:0]  eff, reff;
  logic [2:0]  dx, dy;
  logic [22:0] up_sum;
  logic [13:0] step;
  logic        dn_under;
  logic [21:0] dn_diff;
  logic signed [6:0] voff_w, vdp_s;
  logic [4:0]  vabs;
  logic [6:0]  dsel;
  logic [28:0] msel;
  logic [56:0] prodm;
  logic [27:0] rem;
  logic [24:0] q;
  logic [25:0] fsum;
  logic        emit_ld;
  logic [FREQ_W-1:0] fres_c;
  logic [DUTY_W-1:0] dres_c;

  assign note    = rec_r[5:0];
  assign eff     = rec_r[9:6];
  assign data    = rec_r[15:10];
  assign dx      = data[2:0];
  assign dy      = data[5:3];
  assign reff    = rd_rec[9:6];
  assign rdata_f = rd_rec[15:10];
  assign rd_row  = row_r;

  assign stat.brk_hit  = (tick_r == 6'd0) && (reff == EFF_BREAK);
  assign stat.out_free = !ov_r || out_ready;
  assign emit_ld       = cmd.emit && stat.out_free;

  assign step     = {data, 8'd0};
  assign up_sum   = {1'b0, base_r} + {9'd0, step};
  assign dn_under = base_r < {8'd0, step};
  assign dn_diff  = base_r - {8'd0, step};

  always_comb begin
    voff_w = 7'(voff_r);
    vdp_s  = 7'(vdp_nxt);
    case (vdir_r)
      2'sb01:  voff_w = 7'(voff_r) + $signed({4'd0, vsp_nxt});
      2'sb11:  voff_w = 7'(voff_r) - $signed({4'd0, vsp_nxt});
      default: voff_w = 7'(voff_r);
    endcase
    vdp_s = $signed({4'd0, vdp_nxt});
  end

  always_comb begin
    row_nxt     = row_r;
    tick_nxt    = tick_r;
    tpr_nxt     = tpr_r;
    ph_nxt      = ph_r;
    base_nxt    = base_r;
    tgt_nxt     = tgt_r;
    tgt_vld_nxt = tgt_vld_r;
    active_nxt  = active_r;
    vsp_nxt     = vsp_r;
    vdp_nxt     = vdp_r;
    vdir_nxt    = vdir_r;
    voff_nxt    = voff_r;

    if (cmd.brk) begin
      row_nxt = rdata_f[ROW_W-1:0];
    end

    if (cmd.row_start && tick_r == 6'd0) begin
      if (eff == EFF_SPEED) begin
        tpr_nxt = data;
      end
      if (note == NOTE_RELEASE) begin
        active_nxt = 1'b0;
      end else if (note != NOTE_EMPTY) begin
        active_nxt = 1'b1;
        vsp_nxt    = 3'd0;
        vdp_nxt    = 3'd0;
        vdir_nxt   = 2'sd0;
        voff_nxt   = 5'sd0;
        if (eff == EFF_PORTA) begin
          tgt_nxt     = pitch_of(note);
          tgt_vld_nxt = 1'b1;
        end else begin
          base_nxt    = pitch_of(note);
          tgt_vld_nxt = 1'b0;
        end
      end
    end

    if (cmd.slide && active_r) begin
      if (dx != 3'd0) vsp_nxt = dx;
      if (dy != 3'd0) vdp_nxt = dy;
      case (eff)
        EFF_UP:   base_nxt = up_sum[22] ? FREQ_MAX : up_sum[21:0];
        EFF_DOWN: base_nxt = dn_under ? '0 : dn_diff;
        EFF_PORTA: begin
          if (tgt_vld_r) begin
            if (tgt_r > base_r) begin
              if (up_sum > {1'b0, tgt_r}) begin
                base_nxt    = tgt_r;
                tgt_vld_nxt = 1'b0;
              end else begin
                base_nxt = up_sum[21:0];
              end
            end else if (tgt_r < base_r) begin
              if (dn_under || dn_diff < tgt_r) begin
                base_nxt    = tgt_r;
                tgt_vld_nxt = 1'b0;
              end else begin
                base_nxt = dn_diff;
              end
            end
          end
        end
        EFF_VIB: begin
          voff_nxt = voff_w[4:0];
          if (voff_w > vdp_s) begin
            vdir_nxt = -2'sd1;
          end else if (voff_w < -vdp_s) begin
            vdir_nxt = 2'sd1;
          end else if (vdir_r == 2'sd0) begin
            vdir_nxt = 2'sd1;
          end
        end
        default: ;
      endcase
      if (eff != EFF_VIB) begin
        vsp_nxt = vsp_r;
        vdp_nxt = vdp_r;
      end
    end

    if (emit_ld) begin
      tick_nxt = tick_r + 6'd1;
      ph_nxt   = (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
      if (tick_nxt == 6'd0) begin
        ph_nxt = 2'd0;
      end
      if (tick_nxt >= tpr_r) begin
        tick_nxt = 6'd0;
        ph_nxt   = 2'd0;
        row_nxt  = (row_r == ROW_W'(PATTERN_ROWS - 1)) ? '0 : row_r + 1'b1;
      end
    end
  end

  // divider unit: q = floor(prod / d) via reciprocal and one correction
  assign vabs = voff_r[4] ? 5'(-voff_r) : 5'(voff_r);

  always_comb begin
    case (mode_r)
      MD_ARP:  begin dsel = 7'd12; msel = RECIP_12; end
      MD_VIB:  begin dsel = 7'd84; msel = RECIP_84; end
      default: begin dsel = 7'd63; msel = RECIP_63; end
    endcase
  end

  assign prodm = {29'd0, prod_r} * {28'd0, msel};
  assign rem   = prod_r - ({3'd0, qe_r} * {21'd0, dsel});
  assign q     = qe_r + {24'd0, (rem >= {21'd0, dsel})};
  assign fsum  = {4'd0, base_r} + {1'b0, q};

  // pitch and duty of this tick; silent ticks give zeros
  always_comb begin
    fres_c = base_r;
    dres_c = DUTY_HALF;
    case (mode_r)
      MD_ARP: fres_c = (fsum > {4'd0, FREQ_MAX}) ? FREQ_MAX : fsum[21:0];
      MD_VIB: begin
        if (voff_r[4]) begin
          fres_c = base_r - q[21:0];
        end else begin
          fres_c = (fsum > {4'd0, FREQ_MAX}) ? FREQ_MAX : fsum[21:0];
        end
      end
      MD_PWM:  dres_c = DUTY_MIN + q[15:0];
      default: ;
    endcase
    if (!active_r) begin
      fres_c = '0;
      dres_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      tick_r    <= '0;
      tpr_r     <= 6'd2;
      ph_r      <= '0;
      base_r    <= '0;
      tgt_r     <= '0;
      tgt_vld_r <= 1'b0;
      active_r  <= 1'b0;
      vsp_r     <= '0;
      vdp_r     <= '0;
      vdir_r    <= '0;
      voff_r    <= '0;
      ov_r      <= 1'b0;
      mode_r    <= MD_NONE;
    end else begin
      row_r     <= row_nxt;
      tick_r    <= tick_nxt;
      tpr_r     <= tpr_nxt;
      ph_r      <= ph_nxt;
      base_r    <= base_nxt;
      tgt_r     <= tgt_nxt;
      tgt_vld_r <= tgt_vld_nxt;
      active_r  <= active_nxt;
      vsp_r     <= vsp_nxt;
      vdp_r     <= vdp_nxt;
      vdir_r    <= vdir_nxt;
      voff_r    <= voff_nxt;
      ov_r      <= emit_ld ? 1'b1 : (out_ready ? 1'b0 : ov_r);
      if (cmd.mul) begin
        if (!active_r) begin
          mode_r <= MD_NONE;
        end else if (eff == EFF_ARP && data != 6'd0 && ph_r != 2'd0) begin
          mode_r <= MD_ARP;
        end else if (eff == EFF_VIB) begin
          mode_r <= MD_VIB;
        end else if (eff == EFF_PWM) begin
          mode_r <= MD_PWM;
        end else begin
          mode_r <= MD_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rec) begin
      rec_r <= rd_rec;
    end
    if (cmd.mul) begin
      if (eff == EFF_PWM) begin
        prod_r <= 28'({6'd0, DUTY_SPAN} * {22'd0, data});
      end else if (eff == EFF_VIB) begin
        prod_r <= 28'({6'd0, base_r} * {23'd0, vabs});
      end else begin
        prod_r <= 28'({6'd0, base_r} * {25'd0, (ph_r == 2'd1) ? dx : dy});
      end
    end
    if (cmd.recip) begin
      qe_r <= prodm[56:32];
    end
    if (cmd.corr) begin
      fres_r <= fres_c;
      dres_r <= dres_c;
    end
    if (emit_ld) begin
      out_playing <= active_r;
      out_freq    <= fres_r;
      out_duty    <= dres_r;
      out_row     <= row_r;
    end
  end

  assign out_valid = ov_r;

endmodule

FILE: design/tracker_channel_effect_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tracker_channel_effect_sequencer: one-channel tracker player
// Pattern store plus a sequenced effect datapath; one result per tick request.
// ---------------------------------------------------------------------------
// A write request (tuser 0) stores a note record in the 64-row pattern RAM and
// gives no result. A tick request (tuser 1) runs from acceptance through the
// RAM's registered read and the shared multiply / reciprocal divide unit
// (three register stages) to a loaded result; a row that carries a break on
// tick 0 takes a second RAM read first. The result loads once the result
// register is free, and the next request is taken in the cycle after the
// result loads. One request is worked on at a time; the result register lets
// the next request in while a result waits. Rows must be written before they
// play.
module tracker_channel_effect_sequencer
  import tces_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // entry_index[5:0], entry_record[21:6], zero pad
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // playing[0], tone_frequency[22:1],
                                  // pwm_duty[38:23], row_played[44:39], zero pad
);

  cmd_t              cmd;
  stat_t             stat;
  logic [REC_W-1:0]  rd_rec;
  logic [ROW_W-1:0]  rd_row;
  logic              wr_en;
  logic              o_play;
  logic [FREQ_W-1:0] o_freq;
  logic [DUTY_W-1:0] o_duty;
  logic [ROW_W-1:0]  o_row;

  // writes beyond the pattern are dropped
  assign wr_en = in_tvalid && in_tready && (in_tuser == OP_WRITE)
                 && ({1'b0, in_tdata[5:0]} < 7'(PATTERN_ROWS));

  tces_ram #(.W(REC_W), .DEPTH(PATTERN_ROWS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_tdata[ROW_W-1:0]),
    .wdata (in_tdata[21:6]),
    .raddr (rd_row),
    .rdata (rd_rec)
  );

  tces_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_op    (in_tuser),
    .stat      (stat),
    .req_ready (in_tready),
    .cmd       (cmd)
  );

  tces_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_rec      (rd_rec),
    .out_ready   (out_tready),
    .stat        (stat),
    .rd_row      (rd_row),
    .out_valid   (out_tvalid),
    .out_playing (o_play),
    .out_freq    (o_freq),
    .out_duty    (o_duty),
    .out_row     (o_row)
  );

  assign out_tdata = {3'd0, o_row, o_duty, o_freq, o_play};

  // a silent result carries zero pitch and duty
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[38:1] == 38'd0)
    else $error("silent result with nonzero pitch or duty");

  // duty never exceeds one half
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[38:23] <= DUTY_HALF)
    else $error("duty above one half");

  // an accepted request never shows a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule
